>>> hw/rtl/sm3_hash_core_assert.svh
// Assertion macros shared by the checker.
`ifndef SM3_HASH_CORE_ASSERT_SVH
`define SM3_HASH_CORE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define SM3_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define SM3_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/sm3_pkg.sv
package sm3_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned QueueDepth = 2;

   localparam logic [31:0] IV0 = 32'h7380166F;
   localparam logic [31:0] IV1 = 32'h4914B2B9;
   localparam logic [31:0] IV2 = 32'h172442D7;
   localparam logic [31:0] IV3 = 32'hDA8A0600;
   localparam logic [31:0] IV4 = 32'hA96F30BC;
   localparam logic [31:0] IV5 = 32'h163138AA;
   localparam logic [31:0] IV6 = 32'hE38DEE4D;
   localparam logic [31:0] IV7 = 32'hB0FB0E4E;
   localparam logic [31:0] T_LOW  = 32'h79cc4519;
   localparam logic [31:0] T_HIGH = 32'h7a879d8a;
   localparam logic [31:0] PAD_WORD = 32'h80000000;

   // Word handed from the front end to the compression engine
   typedef struct packed {
      logic [31:0] word;
      logic        block_end;   // sixteenth word of a block
      logic        msg_end;     // last word of message: emit digest after
   } blk_word_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} << n;
      return d[63:32];
   endfunction

   function automatic logic [31:0] perm0(input logic [31:0] x);
      return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
   endfunction

   function automatic logic [31:0] perm1(input logic [31:0] x);
      return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
   endfunction

endpackage

>>> hw/rtl/sm3_front.sv
// Front end: counts bits, applies padding, tags block and message ends.
module sm3_front
   import sm3_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [31:0]  in_word,
   input  logic [2:0]   in_nbytes,
   input  logic         in_last,
   output logic         out_valid,
   input  logic         out_ready,
   output blk_word_type out_data
);

   localparam logic [2:0] S_DATA = 3'd0;
   localparam logic [2:0] S_MARK = 3'd1;
   localparam logic [2:0] S_ZERO = 3'd2;
   localparam logic [2:0] S_LENH = 3'd3;
   localparam logic [2:0] S_LENL = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [3:0]  fill_ff, fill_in;
   logic [63:0] len_ff, len_in;
   logic [2:0]  nb;
   logic [31:0] keep, mark, word;
   logic        push;

   assign nb   = (in_nbytes > 3'd4) ? 3'd4 : in_nbytes;
   assign keep = ~(32'hFFFFFFFF >> {nb, 3'b000});
   assign mark = (nb == 3'd4) ? 32'd0 : (PAD_WORD >> {nb[1:0], 3'b000});

   assign in_ready  = (state_ff == S_DATA) && out_ready;
   assign out_valid = (state_ff == S_DATA) ? in_valid : 1'b1;
   assign push      = out_valid && out_ready;

   // Word selection and next state
   always_comb begin
      state_in = state_ff;
      len_in   = len_ff;
      word     = 32'd0;
      unique case (state_ff)
         S_DATA: begin
            if (!in_last) begin
               word = in_word;
            end else begin
               word = (in_word & keep) | mark;
            end
            if (push) begin
               len_in = len_ff + (in_last ? {58'd0, nb, 3'b000} : 64'd32);
               if (in_last) begin
                  if (nb == 3'd4) begin
                     state_in = S_MARK;
                  end else if (fill_ff == 4'd13) begin
                     state_in = S_LENH;
                  end else begin
                     state_in = S_ZERO;
                  end
               end
            end
         end
         S_MARK: begin
            word = PAD_WORD;
            if (push) state_in = (fill_ff == 4'd13) ? S_LENH : S_ZERO;
         end
         S_ZERO: begin
            if (push && fill_ff == 4'd13) state_in = S_LENH;
         end
         S_LENH: begin
            word = len_ff[63:32];
            if (push) state_in = S_LENL;
         end
         S_LENL: begin
            word = len_ff[31:0];
            if (push) begin
               state_in = S_DATA;
               len_in   = 64'd0;
            end
         end
         default: state_in = S_DATA;
      endcase
   end

   assign fill_in = push ? fill_ff + 4'd1 : fill_ff;

   assign out_data.word      = word;
   assign out_data.block_end = (fill_ff == 4'd15);
   assign out_data.msg_end   = (state_ff == S_LENL);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_DATA;
         fill_ff  <= 4'd0;
         len_ff   <= 64'd0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         len_ff   <= len_in;
      end
   end

endmodule

>>> hw/rtl/sm3_queue.sv
// Small FIFO between front end and engine.
module sm3_queue
   import sm3_pkg::*;
#(
   parameter int unsigned Depth = QueueDepth
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  blk_word_type in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output blk_word_type out_data
);

   localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

   blk_word_type mem_ff [Depth];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0]   cnt_ff;
   logic          wr, rd;

   assign in_ready  = (cnt_ff != Depth[AW:0]);
   assign out_valid = (cnt_ff != '0);
   assign out_data  = mem_ff[rp_ff];
   assign wr = in_valid && in_ready;
   assign rd = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= in_data;
   end

   // Pointers wrap at the depth
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= (wp_ff == AW'(Depth - 1)) ? '0 : wp_ff + 1'b1;
         if (rd) rp_ff <= (rp_ff == AW'(Depth - 1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + {{AW{1'b0}}, wr} - {{AW{1'b0}}, rd};
      end
   end

endmodule

>>> hw/rtl/sm3_engine.sv
// Compression engine: loads 16 words, runs 64 rounds with on-the-fly
// expansion, chains, and streams out the digest at message end.
module sm3_engine
   import sm3_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  blk_word_type in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [31:0]  out_word,
   output logic [2:0]   out_index,
   output logic         out_last
);

   localparam logic [1:0] E_LOAD = 2'd0;
   localparam logic [1:0] E_RUN  = 2'd1;
   localparam logic [1:0] E_OUT  = 2'd2;

   logic [1:0]  st_ff, st_in;
   logic [31:0] win_ff [16];
   logic [31:0] v_ff [8];
   logic [31:0] cv_ff [8];
   logic [5:0]  rnd_ff;
   logic [2:0]  oi_ff;
   logic        fin_ff;
   logic [31:0] wj, wj4, wnew, tj, a12, ss1, ss2, ff, gg, tt1, tt2;
   logic        low;
   logic        take;

   assign in_ready = (st_ff == E_LOAD);
   assign take     = in_valid && in_ready;
   assign low      = (rnd_ff < 6'd16);

   // Window holds W[j..j+15]; new word W[j+16] shifts in each round
   assign wj   = win_ff[0];
   assign wj4  = win_ff[4];
   assign wnew = perm1(win_ff[0] ^ win_ff[7] ^ rotl(win_ff[13], 5'd15))
                 ^ rotl(win_ff[3], 5'd7) ^ win_ff[10];
   assign tj   = rotl(low ? T_LOW : T_HIGH, rnd_ff[4:0]);
   assign a12  = rotl(v_ff[0], 5'd12);
   assign ss1  = rotl(a12 + v_ff[4] + tj, 5'd7);
   assign ss2  = ss1 ^ a12;
   assign ff   = low ? (v_ff[0] ^ v_ff[1] ^ v_ff[2])
                     : ((v_ff[0] & v_ff[1]) | (v_ff[0] & v_ff[2]) | (v_ff[1] & v_ff[2]));
   assign gg   = low ? (v_ff[4] ^ v_ff[5] ^ v_ff[6])
                     : ((v_ff[4] & v_ff[5]) | (~v_ff[4] & v_ff[6]));
   assign tt1  = ff + v_ff[3] + ss2 + (wj ^ wj4);
   assign tt2  = gg + v_ff[7] + ss1 + wj;

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         E_LOAD: if (take && in_data.block_end) st_in = E_RUN;
         E_RUN:  if (rnd_ff == 6'd63) st_in = fin_ff ? E_OUT : E_LOAD;
         E_OUT:  if (out_ready && oi_ff == 3'd7) st_in = E_LOAD;
         default: st_in = E_LOAD;
      endcase
   end

   // Window load and rounds
   always_ff @(posedge clock) begin
      if (take) begin
         for (int i = 0; i < 15; i++) win_ff[i] <= win_ff[i+1];
         win_ff[15] <= in_data.word;
      end else if (st_ff == E_RUN) begin
         for (int i = 0; i < 15; i++) win_ff[i] <= win_ff[i+1];
         win_ff[15] <= wnew;
      end
      if (take && in_data.block_end) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= cv_ff[i];
      end else if (st_ff == E_RUN) begin
         v_ff[0] <= tt1;
         v_ff[1] <= v_ff[0];
         v_ff[2] <= rotl(v_ff[1], 5'd9);
         v_ff[3] <= v_ff[2];
         v_ff[4] <= perm0(tt2);
         v_ff[5] <= v_ff[4];
         v_ff[6] <= rotl(v_ff[5], 5'd19);
         v_ff[7] <= v_ff[6];
      end
   end

   // Chain value, round and output counters
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= E_LOAD;
         rnd_ff <= 6'd0;
         oi_ff  <= 3'd0;
         fin_ff <= 1'b0;
         cv_ff  <= '{IV0, IV1, IV2, IV3, IV4, IV5, IV6, IV7};
      end else begin
         st_ff <= st_in;
         if (take && in_data.block_end) begin
            fin_ff <= in_data.msg_end;
            rnd_ff <= 6'd0;
         end else if (st_ff == E_RUN) begin
            rnd_ff <= rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) begin
               cv_ff[0] <= cv_ff[0] ^ tt1;
               cv_ff[1] <= cv_ff[1] ^ v_ff[0];
               cv_ff[2] <= cv_ff[2] ^ rotl(v_ff[1], 5'd9);
               cv_ff[3] <= cv_ff[3] ^ v_ff[2];
               cv_ff[4] <= cv_ff[4] ^ perm0(tt2);
               cv_ff[5] <= cv_ff[5] ^ v_ff[4];
               cv_ff[6] <= cv_ff[6] ^ rotl(v_ff[5], 5'd19);
               cv_ff[7] <= cv_ff[7] ^ v_ff[6];
            end
         end else if (st_ff == E_OUT && out_ready) begin
            oi_ff <= oi_ff + 3'd1;
            if (oi_ff == 3'd7) begin
               cv_ff <= '{IV0, IV1, IV2, IV3, IV4, IV5, IV6, IV7};
            end
         end
      end
   end

   assign out_valid = (st_ff == E_OUT);
   assign out_word  = cv_ff[oi_ff];
   assign out_index = oi_ff;
   assign out_last  = (oi_ff == 3'd7);

endmodule

>>> hw/rtl/sm3_hash_core.sv
// SM3 hash core.
// Input (req_): one message word per transfer, big-endian bytes. tdata
// holds message_word in [31:0] and valid_bytes in [34:32]; tlast marks
// the final word. valid_bytes is read on the final word only (above 4
// counts as 4).
// Output (rsp_): eight transfers per message, the digest words in order.
// tdata holds digest_word [31:0] and word_index [34:32]; tlast is high on
// word 7.
// Per 512-bit block the engine loads 16 words, then runs 64 rounds (one round a
// cycle) and takes no new word until the rounds are done.
// Padding fills out the block of the final word and may need one more block;
// the first digest word is valid once the engine leaves its rounds for the
// output state.
// The front end keeps taking words into a short queue while the engine is
// busy. A stalled rsp_ receiver holds the engine; the queue then fills and
// req_tready drops. Reset loads the initial vector and clears all counts;
// after each digest the core starts a new message by itself.
module sm3_hash_core
   import sm3_pkg::*;
#(
   parameter int unsigned QDepth = QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // message_word, valid_bytes, zero fill
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // digest_word, word_index, zero fill
   output logic        rsp_tlast
);

   blk_word_type f_data, q_data;
   logic f_valid, f_ready, q_valid, q_ready;
   logic [31:0] d_word;
   logic [2:0]  d_index;

   sm3_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_word(req_tdata[31:0]), .in_nbytes(req_tdata[34:32]), .in_last(req_tlast),
      .out_valid(f_valid), .out_ready(f_ready), .out_data(f_data)
   );

   sm3_queue #(.Depth(QDepth)) u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   sm3_engine u_engine (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_word(d_word), .out_index(d_index), .out_last(rsp_tlast)
   );

   assign rsp_tdata = {5'd0, d_index, d_word};

endmodule

>>> hw/rtl/sm3_checker.sv
`include "sm3_hash_core_assert.svh"
// Port-level checks of the hash core.
module sm3_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [39:0] req_tdata,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);

   `SM3_ASSERT_IMPL(a_last_idx, clock, reset, rsp_tvalid,
      rsp_tlast == (rsp_tdata[34:32] == 3'd7), "tlast not on word 7")
   `SM3_ASSERT_IMPL(a_pad_zero, clock, reset, rsp_tvalid,
      rsp_tdata[39:35] == 5'd0, "fill bits set")
   `SM3_ASSERT_NEXT(a_idx_step, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast,
      rsp_tvalid && rsp_tdata[34:32] == $past(rsp_tdata[34:32]) + 3'd1, "index skip")
   `SM3_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "stalled digest changed")

endmodule

bind sm3_hash_core sm3_checker u_checker (.*);
